// File: hdl/stress_tensor_cylindrical_rotation_macros.svh
// assertion macros for the stress tensor rotation block
// no dependencies
`ifndef STRESS_TENSOR_CYLINDRICAL_ROTATION_MACROS_SVH
`define STRESS_TENSOR_CYLINDRICAL_ROTATION_MACROS_SVH
// implication checked in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
// same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`endif

// File: hdl/stcr_pkg.sv
// types and helpers for the stress tensor rotation block
// no dependencies
package stcr_pkg;
	typedef struct packed {
		logic signed [31:0] s_xx, s_yy, s_zz, s_xy, s_xz, s_yz, s_yx, s_zx, s_zy;
		logic signed [31:0] pos_y, pos_z;
		logic in_group;
	} stcr_in_t;
	typedef struct packed {
		logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_yx, r_zx, r_zy;
		logic saturated;
	} stcr_out_t;
	localparam logic [0:0] REG_CYL = 1'd0;
	localparam logic [0:0] REG_SCALE = 1'd1;
	localparam int NSQ = 32;
	localparam int NDIV = 32;
endpackage

// File: hdl/stcr_angle.sv
// angle unit: normalize, pipelined square root and division, gives cos and sin in q1.30
// uses stcr_pkg
module stcr_angle import stcr_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	output logic signed [31:0] c,
	output logic signed [31:0] s
);
	// stage 0: normalize
	logic [31:0] my, mz, mx;
	logic [5:0] sh;
	logic [31:0] yn0, zn0;
	always_comb begin
		my = py[31] ? 32'(-py) : 32'(py);
		mz = pz[31] ? 32'(-pz) : 32'(pz);
		mx = (my > mz) ? my : mz;
		sh = '0;
		// highest set bit wins
		for (int i = 0; i < 32; i++) if (mx[i]) sh = 6'(i);
		sh = 6'(30) - sh;
		if (mx[31]) sh = 6'd0;
		yn0 = my << sh;
		zn0 = mz << sh;
	end
	// square root pipeline
	logic [63:0] rem_q [0:NSQ];
	logic [32:0] res_q [0:NSQ];
	logic [31:0] yq [0:NSQ], zq [0:NSQ];
	logic sy [0:NSQ], sz [0:NSQ], zr [0:NSQ];
	always_ff @(posedge clk) begin
		rem_q[0] <= 64'(yn0) * 64'(yn0) + 64'(zn0) * 64'(zn0);
		res_q[0] <= '0;
		yq[0] <= yn0;
		zq[0] <= zn0;
		sy[0] <= py[31];
		sz[0] <= pz[31];
		zr[0] <= (mx == 0);
		for (int i = 0; i < NSQ; i++) begin
			logic [65:0] t;
			t = {2'b0, (64'(res_q[i]) << 2) | 64'd1} << (62 - 2*i);
			if ({2'b0, rem_q[i]} >= t) begin
				rem_q[i+1] <= rem_q[i] - t[63:0];
				res_q[i+1] <= (res_q[i] << 1) | 33'd1;
			end else begin
				rem_q[i+1] <= rem_q[i];
				res_q[i+1] <= res_q[i] << 1;
			end
			yq[i+1] <= yq[i];
			zq[i+1] <= zq[i];
			sy[i+1] <= sy[i];
			sz[i+1] <= sz[i];
			zr[i+1] <= zr[i];
		end
	end
	// restoring division of (m<<30 + r/2) by r, both numerators at once
	logic [32:0] rd [0:NDIV];
	logic [63:0] ny [0:NDIV], nz [0:NDIV];
	logic [63:0] ry [0:NDIV], rz [0:NDIV];
	logic [31:0] qy [0:NDIV], qz [0:NDIV];
	logic dy [0:NDIV], dz [0:NDIV], dzr [0:NDIV];
	always_ff @(posedge clk) begin
		rd[0] <= res_q[NSQ];
		ny[0] <= (64'(yq[NSQ]) << 30) + 64'(res_q[NSQ] >> 1);
		nz[0] <= (64'(zq[NSQ]) << 30) + 64'(res_q[NSQ] >> 1);
		ry[0] <= '0;
		rz[0] <= '0;
		qy[0] <= '0;
		qz[0] <= '0;
		dy[0] <= sy[NSQ];
		dz[0] <= sz[NSQ];
		dzr[0] <= zr[NSQ];
		for (int i = 0; i < NDIV; i++) begin
			logic [64:0] ty, tz;
			// quotient fits in 31 bits; each step brings in two numerator bits
			ty = {ry[i][62:0], ny[i][63:62]};
			tz = {rz[i][62:0], nz[i][63:62]};
			begin
				logic [64:0] a1, b1;
				logic q1, q2, p1, p2;
				q1 = ({1'b0, ty[64:1]} >= 65'(rd[i]));
				a1 = q1 ? {1'b0, ty[64:1]} - 65'(rd[i]) : {1'b0, ty[64:1]};
				a1 = {a1[63:0], ty[0]};
				q2 = (a1 >= 65'(rd[i]));
				if (q2) a1 = a1 - 65'(rd[i]);
				p1 = ({1'b0, tz[64:1]} >= 65'(rd[i]));
				b1 = p1 ? {1'b0, tz[64:1]} - 65'(rd[i]) : {1'b0, tz[64:1]};
				b1 = {b1[63:0], tz[0]};
				p2 = (b1 >= 65'(rd[i]));
				if (p2) b1 = b1 - 65'(rd[i]);
				ry[i+1] <= a1[63:0];
				rz[i+1] <= b1[63:0];
				qy[i+1] <= {qy[i][29:0], q1, q2};
				qz[i+1] <= {qz[i][29:0], p1, p2};
			end
			ny[i+1] <= ny[i] << 2;
			nz[i+1] <= nz[i] << 2;
			rd[i+1] <= rd[i];
			dy[i+1] <= dy[i];
			dz[i+1] <= dz[i];
			dzr[i+1] <= dzr[i];
		end
	end
	always_comb begin
		if (dzr[NDIV]) begin
			c = 32'sd1073741824;
			s = '0;
		end else begin
			c = dy[NDIV] ? -$signed(qy[NDIV]) : $signed(qy[NDIV]);
			s = dz[NDIV] ? -$signed(qz[NDIV]) : $signed(qz[NDIV]);
		end
	end
endmodule

// File: hdl/stress_tensor_cylindrical_rotation.sv
// one request accepted every cycle
// the angle unit sets the depth: 66 stages (square, 32 root bits, divide setup, 32 bit pairs)
// then trig products, rotation sums, scale products, round and saturate
// arst_n clears valid bits and the registers to cyl_enable=0, unit_scale=-1.0
// the receiver cannot stall, so the pipeline never holds
// uses stcr_pkg, stcr_angle and the macros header
`include "stress_tensor_cylindrical_rotation_macros.svh"
module stress_tensor_cylindrical_rotation import stcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  stcr_in_t    req,
	output logic        done,
	output stcr_out_t   rsp,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	localparam int AL = NSQ + NDIV + 2;
	localparam int LAT = AL + 4;
	logic cyl_q;
	logic signed [31:0] scale_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_q <= 1'b0;
			scale_q <= -32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CYL:   cyl_q <= cfg_data[0];
				REG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end
	assign busy = 1'b0;
	logic acc;
	assign acc = start && !busy;
	// angle unit runs alongside a delay line for the tensor
	logic signed [31:0] c, s;
	stcr_angle u_ang (.clk(clk), .py(req.pos_y), .pz(req.pos_z),
		.c(c), .s(s));
	stcr_in_t dl [0:AL-1];
	logic v [1:LAT];
	always_ff @(posedge clk) begin
		dl[0] <= req;
		for (int i = 1; i < AL; i++) dl[i] <= dl[i-1];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) v[i] <= 1'b0;
		end else begin
			v[1] <= acc;
			for (int i = 2; i <= LAT; i++) v[i] <= v[i-1];
		end
	end
	stcr_in_t t;
	assign t = dl[AL-1];
	function automatic logic signed [95:0] rs30(input logic signed [95:0] x);
		logic [95:0] m;
		m = x[95] ? 96'(-x) : 96'(x);
		m = (m + (96'd1 << 29)) >> 30;
		return x[95] ? -$signed(m) : $signed(m);
	endfunction
	// stage a: trig products
	logic signed [31:0] cc_a, cs_a, ss_a, c_a, s_a;
	stcr_in_t t_a;
	always_ff @(posedge clk) begin
		c_a <= c; s_a <= s; t_a <= t;
		cc_a <= 32'(rs30(96'(64'(c) * 64'(c))));
		cs_a <= 32'(rs30(96'(64'(c) * 64'(s))));
		ss_a <= 32'(rs30(96'(64'(s) * 64'(s))));
	end
	// stage b: rotation sums
	logic signed [63:0] rot_b [0:8];
	logic g_b;
	always_ff @(posedge clk) begin
		logic signed [95:0] f, m, g, k, b, d, e, h;
		f = 96'(t_a.s_yy); m = 96'(t_a.s_zz); g = 96'(t_a.s_yz); k = 96'(t_a.s_zy);
		b = 96'(t_a.s_xy); d = 96'(t_a.s_xz); e = 96'(t_a.s_yx); h = 96'(t_a.s_zx);
		g_b <= t_a.in_group;
		rot_b[0] <= 64'(t_a.s_xx);
		if (cyl_q) begin
			rot_b[3] <= 64'(rs30(b*c_a + d*s_a));
			rot_b[4] <= 64'(rs30(d*c_a - b*s_a));
			rot_b[6] <= 64'(rs30(e*c_a + h*s_a));
			rot_b[7] <= 64'(rs30(h*c_a - e*s_a));
			rot_b[1] <= 64'(rs30(f*cc_a + g*cs_a + k*cs_a + m*ss_a));
			rot_b[2] <= 64'(rs30(f*ss_a - g*cs_a - k*cs_a + m*cc_a));
			rot_b[5] <= 64'(rs30(m*cs_a - f*cs_a + g*cc_a - k*ss_a));
			rot_b[8] <= 64'(rs30(m*cs_a - f*cs_a + k*cc_a - g*ss_a));
		end else begin
			rot_b[1] <= 64'(t_a.s_yy); rot_b[2] <= 64'(t_a.s_zz);
			rot_b[3] <= 64'(t_a.s_xy); rot_b[4] <= 64'(t_a.s_xz);
			rot_b[5] <= 64'(t_a.s_yz); rot_b[6] <= 64'(t_a.s_yx);
			rot_b[7] <= 64'(t_a.s_zx); rot_b[8] <= 64'(t_a.s_zy);
		end
	end
	// stage c: scale products, rotated magnitudes stay within 34 bits
	logic [65:0] pr_c [0:8];
	logic ng_c [0:8];
	logic g_c;
	always_ff @(posedge clk) begin
		logic [31:0] ms;
		logic [33:0] mv;
		g_c <= g_b;
		ms = scale_q[31] ? 32'(-scale_q) : 32'(scale_q);
		for (int i = 0; i < 9; i++) begin
			mv = rot_b[i][63] ? 34'(-rot_b[i]) : 34'(rot_b[i]);
			pr_c[i] <= 66'(mv) * 66'(ms);
			ng_c[i] <= rot_b[i][63] != scale_q[31];
		end
	end
	// stage d: round and saturate
	stcr_out_t o_d;
	always_ff @(posedge clk) begin
		logic [65:0] m;
		logic [31:0] r [0:8];
		logic sat;
		sat = 1'b0;
		for (int i = 0; i < 9; i++) begin
			m = (pr_c[i] + 66'd32768) >> 16;
			if (m == 0) r[i] = '0;
			else if (ng_c[i]) begin
				if (m > 66'h80000000) begin sat = 1'b1; m = 66'h80000000; end
				r[i] = 32'(-m);
			end else begin
				if (m > 66'h7FFFFFFF) begin sat = 1'b1; m = 66'h7FFFFFFF; end
				r[i] = m[31:0];
			end
			if (!g_c) r[i] = '0;
		end
		o_d <= {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], sat & g_c};
	end
	assign done = v[LAT];
	assign rsp = o_d;
	`ASSERT_NEXT(a_pipe, clk, arst_n, acc, v[1])
	`ASSERT_NOW(a_never_busy, clk, arst_n, start, !busy)
	`ASSERT_NOW(a_sat_group, clk, arst_n, done && rsp.saturated, rsp != '0)
endmodule

// File: test/tb.sv
// testbench for stress_tensor_cylindrical_rotation: directed table then random requests
// every response checked field by field against a typed-in answer or a built-in fixed-point predictor
// depends on stcr_pkg and the rtl of the block
module tb;
	import stcr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	stcr_in_t    req;
	logic        done;
	stcr_out_t   rsp;
	logic        cfg_we;
	logic [0:0]  cfg_idx;
	logic [31:0] cfg_data;

	stress_tensor_cylindrical_rotation dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor copy of the two registers
	logic               cyl_on;
	logic signed [31:0] scale_q16;

	// tensors still owed by the block, oldest first
	stcr_out_t pending_tensors[$];
	int        mismatches;
	int        n_requests;
	int        n_responses;
	int        n_saturated;
	int        send_gap_pct;

	// directed stimulus row: request plus optional typed-in answer
	typedef struct {
		stcr_in_t  rq;
		bit        typed;
		stcr_out_t ans;
	} dir_row_t;
	dir_row_t dir_rows[$];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// shift right with round to nearest, ties away from zero
	function automatic longint round_shift(longint v, int n);
		longint unsigned m;
		m = (mag(v) + (64'd1 << (n - 1))) >> n;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// scale one component into Q16.16 and clip
	function automatic logic [31:0] scale_clip(longint v, inout logic clipped);
		longint unsigned prod, m;
		bit neg;
		prod = mag(v) * mag(longint'(scale_q16));
		m = (prod + 64'd32768) >> 16;
		neg = (v < 0) != (scale_q16 < 0);
		if (m == 0)
			return 32'd0;
		if (neg) begin
			if (m > 64'h8000_0000) begin
				clipped = 1'b1;
				m = 64'h8000_0000;
			end
			return 32'(-longint'(m));
		end
		if (m > 64'h7fff_ffff) begin
			clipped = 1'b1;
			m = 64'h7fff_ffff;
		end
		return 32'(m);
	endfunction

	function automatic stcr_out_t rotate_tensor(stcr_in_t q);
		stcr_out_t o;
		longint xx, yy, zz, xy, xz, yz, yx, zx, zy;
		longint c, s, cc, cs, ss;
		longint unsigned my, mz, mx, r;
		logic clipped;
		o = '0;
		if (!q.in_group)
			return o;
		xx = q.s_xx; yy = q.s_yy; zz = q.s_zz; xy = q.s_xy; xz = q.s_xz;
		yz = q.s_yz; yx = q.s_yx; zx = q.s_zx; zy = q.s_zy;
		if (cyl_on) begin
			c = 64'sd1 << 30;
			s = 0;
			my = mag(longint'(q.pos_y));
			mz = mag(longint'(q.pos_z));
			mx = my > mz ? my : mz;
			// origin keeps angle zero
			if (mx != 0) begin
				while (mx < (64'd1 << 30)) begin
					mx <<= 1; my <<= 1; mz <<= 1;
				end
				r = int_sqrt(my * my + mz * mz);
				c = longint'(((my << 30) + (r >> 1)) / r);
				s = longint'(((mz << 30) + (r >> 1)) / r);
				if (q.pos_y < 0) c = -c;
				if (q.pos_z < 0) s = -s;
			end
			cc = round_shift(c * c, 30);
			cs = round_shift(c * s, 30);
			ss = round_shift(s * s, 30);
			xy = round_shift(longint'(q.s_xy) * c + longint'(q.s_xz) * s, 30);
			xz = round_shift(longint'(q.s_xz) * c - longint'(q.s_xy) * s, 30);
			yx = round_shift(longint'(q.s_yx) * c + longint'(q.s_zx) * s, 30);
			zx = round_shift(longint'(q.s_zx) * c - longint'(q.s_yx) * s, 30);
			yy = round_shift(longint'(q.s_yy) * cc + longint'(q.s_yz) * cs
				+ longint'(q.s_zy) * cs + longint'(q.s_zz) * ss, 30);
			zz = round_shift(longint'(q.s_yy) * ss - longint'(q.s_yz) * cs
				- longint'(q.s_zy) * cs + longint'(q.s_zz) * cc, 30);
			yz = round_shift(longint'(q.s_zz) * cs - longint'(q.s_yy) * cs
				+ longint'(q.s_yz) * cc - longint'(q.s_zy) * ss, 30);
			zy = round_shift(longint'(q.s_zz) * cs - longint'(q.s_yy) * cs
				+ longint'(q.s_zy) * cc - longint'(q.s_yz) * ss, 30);
		end
		clipped = 1'b0;
		o.r_xx = scale_clip(xx, clipped);
		o.r_yy = scale_clip(yy, clipped);
		o.r_zz = scale_clip(zz, clipped);
		o.r_xy = scale_clip(xy, clipped);
		o.r_xz = scale_clip(xz, clipped);
		o.r_yz = scale_clip(yz, clipped);
		o.r_yx = scale_clip(yx, clipped);
		o.r_zx = scale_clip(zx, clipped);
		o.r_zy = scale_clip(zy, clipped);
		o.saturated = clipped;
		return o;
	endfunction

	// response checker: the receiver never stalls, so every done cycle is taken
	always @(posedge clk) begin
		stcr_out_t want;
		if (arst_n && done) begin
			n_responses++;
			if (pending_tensors.size() == 0) begin
				$error("response with nothing outstanding");
				mismatches++;
			end else begin
				want = pending_tensors.pop_front();
				if (rsp.saturated) n_saturated++;
				if (rsp.r_xx !== want.r_xx) begin
					$error("r_xx exp %h got %h", want.r_xx, rsp.r_xx); mismatches++;
				end
				if (rsp.r_yy !== want.r_yy) begin
					$error("r_yy exp %h got %h", want.r_yy, rsp.r_yy); mismatches++;
				end
				if (rsp.r_zz !== want.r_zz) begin
					$error("r_zz exp %h got %h", want.r_zz, rsp.r_zz); mismatches++;
				end
				if (rsp.r_xy !== want.r_xy) begin
					$error("r_xy exp %h got %h", want.r_xy, rsp.r_xy); mismatches++;
				end
				if (rsp.r_xz !== want.r_xz) begin
					$error("r_xz exp %h got %h", want.r_xz, rsp.r_xz); mismatches++;
				end
				if (rsp.r_yz !== want.r_yz) begin
					$error("r_yz exp %h got %h", want.r_yz, rsp.r_yz); mismatches++;
				end
				if (rsp.r_yx !== want.r_yx) begin
					$error("r_yx exp %h got %h", want.r_yx, rsp.r_yx); mismatches++;
				end
				if (rsp.r_zx !== want.r_zx) begin
					$error("r_zx exp %h got %h", want.r_zx, rsp.r_zx); mismatches++;
				end
				if (rsp.r_zy !== want.r_zy) begin
					$error("r_zy exp %h got %h", want.r_zy, rsp.r_zy); mismatches++;
				end
				if (rsp.saturated !== want.saturated) begin
					$error("saturated exp %b got %b", want.saturated, rsp.saturated);
					mismatches++;
				end
			end
		end
	end

	// register write at one edge, predictor follows
	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx == REG_CYL)
			cyl_on = val[0];
		else
			scale_q16 = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_tensors.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// hold start with the request until accepted; start stays high across back-to-back
	task automatic issue(stcr_in_t q, stcr_out_t want);
		start <= 1'b1;
		req <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_tensors.push_back(want);
		n_requests++;
	endtask

	// optional idle cycles between requests
	task automatic maybe_idle();
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			req <= '0;
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(200000)) - 100000);
			3: return 32'd0;
			4: return 32'($urandom_range(1)) ? 32'h0001_0000 : 32'hffff_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic stcr_in_t rand_tensor();
		stcr_in_t q;
		q.s_xx = rand_word(); q.s_yy = rand_word(); q.s_zz = rand_word();
		q.s_xy = rand_word(); q.s_xz = rand_word(); q.s_yz = rand_word();
		q.s_yx = rand_word(); q.s_zx = rand_word(); q.s_zy = rand_word();
		q.pos_y = rand_word();
		q.pos_z = $urandom_range(9) == 0 ? q.pos_y : rand_word();
		if ($urandom_range(15) == 0) begin
			q.pos_y = 0;
			q.pos_z = 0;
		end
		q.in_group = $urandom_range(9) != 0;
		return q;
	endfunction

	function automatic stcr_in_t fill_tensor(logic [31:0] v, logic [31:0] py,
		logic [31:0] pz, logic grp);
		stcr_in_t q;
		q.s_xx = v; q.s_yy = v; q.s_zz = v; q.s_xy = v; q.s_xz = v;
		q.s_yz = v; q.s_yx = v; q.s_zx = v; q.s_zy = v;
		q.pos_y = py; q.pos_z = pz; q.in_group = grp;
		return q;
	endfunction

	function automatic stcr_out_t fill_answer(logic [31:0] v, logic sat);
		stcr_out_t o;
		o.r_xx = v; o.r_yy = v; o.r_zz = v; o.r_xy = v; o.r_xz = v;
		o.r_yz = v; o.r_yx = v; o.r_zx = v; o.r_zy = v; o.saturated = sat;
		return o;
	endfunction

	initial begin
		#20_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		stcr_out_t want;
		logic [31:0] scales[6];
		int ph;
		mismatches = 0; n_requests = 0; n_responses = 0; n_saturated = 0;
		send_gap_pct = 0;
		cyl_on = 1'b0;
		scale_q16 = 32'hffff_0000;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_CYL;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, reset config: scale -1.0, no rotation
		// outside group gives zeros even at extremes
		dir_rows.push_back('{fill_tensor(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0),
			1'b1, fill_answer(32'd0, 1'b0)});
		// one times minus one
		dir_rows.push_back('{fill_tensor(32'h0001_0000, 32'd0, 32'd0, 1'b1),
			1'b1, fill_answer(32'hffff_0000, 1'b0)});
		// most negative times minus one clips positive
		dir_rows.push_back('{fill_tensor(32'h8000_0000, 32'd5, 32'd7, 1'b1),
			1'b1, fill_answer(32'h7fff_ffff, 1'b1)});
		// most positive negates without clipping
		dir_rows.push_back('{fill_tensor(32'h7fff_ffff, 32'd0, 32'd0, 1'b1),
			1'b1, fill_answer(32'h8000_0001, 1'b0)});
		dir_rows.push_back('{fill_tensor(32'hffff_ffff, 32'd1, 32'd1, 1'b1),
			1'b1, fill_answer(32'h0000_0001, 1'b0)});
		foreach (dir_rows[i])
			issue(dir_rows[i].rq, dir_rows[i].ans);
		drain();

		// rotation on, scale +1.0: origin, axes, diagonals, extremes
		write_reg(REG_CYL, 32'd1);
		write_reg(REG_SCALE, 32'h0001_0000);
		dir_rows.delete();
		// origin: angle zero so tensor passes through
		dir_rows.push_back('{fill_tensor(32'h0003_0000, 32'd0, 32'd0, 1'b1),
			1'b1, fill_answer(32'h0003_0000, 1'b0)});
		dir_rows.push_back('{fill_tensor(32'h1234_5678, 32'h0001_0000, 32'd0, 1'b1),
			1'b0, '0});
		dir_rows.push_back('{fill_tensor(32'h1234_5678, 32'd0, 32'h0001_0000, 1'b1),
			1'b0, '0});
		dir_rows.push_back('{fill_tensor(32'h8765_4321, 32'hffff_0000, 32'd0, 1'b1),
			1'b0, '0});
		dir_rows.push_back('{fill_tensor(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1),
			1'b0, '0});
		dir_rows.push_back('{fill_tensor(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1),
			1'b0, '0});
		dir_rows.push_back('{fill_tensor(32'h0000_0001, 32'd1, 32'hffff_ffff, 1'b1),
			1'b0, '0});
		dir_rows.push_back('{fill_tensor(32'h4000_0000, 32'd3, 32'd4, 1'b1),
			1'b0, '0});
		foreach (dir_rows[i]) begin
			// rows without a typed answer go to the predictor
			want = dir_rows[i].typed ? dir_rows[i].ans : rotate_tensor(dir_rows[i].rq);
			issue(dir_rows[i].rq, want);
		end
		drain();

		// random phases over several register settings, extremes among them
		scales = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_8000, 32'hffff_0000,
			32'd0, 32'h0001_0000};
		for (ph = 0; ph < 6; ph++) begin
			write_reg(REG_CYL, 32'(ph % 3 != 2));
			write_reg(REG_SCALE, ph == 5 ? $urandom() : scales[ph]);
			send_gap_pct = ph < 2 ? 22 : (ph < 4 ? 63 : 0);
			repeat (320) begin
				stcr_in_t q;
				q = rand_tensor();
				maybe_idle();
				issue(q, rotate_tensor(q));
				// sender holds off until all outstanding responses are back
				if ($urandom_range(99) == 0) begin
					start <= 1'b0;
					@(posedge clk);
					while (pending_tensors.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		$display("covered %0d requests, %0d responses, %0d with clipping",
			n_requests, n_responses, n_saturated);
		$display("register settings: rotation on and off, six scales incl. both extremes");
		if (mismatches == 0 && pending_tensors.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

// File: files.f
+incdir+hdl
hdl/stcr_pkg.sv
hdl/stcr_angle.sv
hdl/stress_tensor_cylindrical_rotation.sv
test/tb.sv
